// ===== rtl/core/delayed_command_timer_table_core_macros.svh =====
// Assertion macros used by the timer table checker.
`ifndef DELAYED_COMMAND_TIMER_TABLE_CORE_MACROS_SVH
`define DELAYED_COMMAND_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DCTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dctt_pkg.sv =====
// Shared types and codes of the delayed command timer table.
package dctt_pkg;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_CREATE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] RC_CREATED   = 3'd0;
    localparam logic [2:0] RC_REFUSED   = 3'd1;
    localparam logic [2:0] RC_FIRED     = 3'd2;
    localparam logic [2:0] RC_TICK_NONE = 3'd3;
    localparam logic [2:0] RC_CLEARED   = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] delay_ticks;
        logic [31:0] target_address;
        logic [31:0] data_word;
        logic [3:0]  command_kind;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [5:0]  slot_index;
        logic [31:0] fired_target;
        logic [31:0] fired_data;
        logic [3:0]  fired_kind;
        logic        last;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CREATE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] delay_ticks;
        logic [31:0] target_address;
        logic [31:0] data_word;
        logic [3:0]  command_kind;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// ===== rtl/core/dctt_front.sv =====
// Front end: accepts input words, decodes the action and queues commands.
module dctt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dctt_pkg::t_in_word i_in_word,
    output logic               o_in_stall,
    output dctt_pkg::t_q_head  o_head,
    input  logic               i_pop
);
    import dctt_pkg::*;

    t_cmd               r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    t_cmd               n_cmd;
    logic               n_keep;
    logic               push;

    always_comb begin
        n_cmd.delay_ticks    = i_in_word.delay_ticks;
        n_cmd.target_address = i_in_word.target_address;
        n_cmd.data_word      = i_in_word.data_word;
        n_cmd.command_kind   = i_in_word.command_kind;
        n_cmd.op             = OP_TICK;
        n_keep               = 1'b1;
        unique case (i_in_word.action)
            ACT_TICK:   n_cmd.op = OP_TICK;
            ACT_CREATE: n_cmd.op = OP_CREATE;
            ACT_CLEAR:  n_cmd.op = OP_CLEAR;
            default:    n_keep   = 1'b0;
        endcase
    end

    assign o_in_stall   = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall && n_keep;
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= n_cmd;
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/dctt_back.sv =====
// Back end: slot table, create/tick/clear sequencer and output register.
module dctt_back #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dctt_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output dctt_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import dctt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CREATE,
        S_TICK
    } t_state;

    logic signed [16:0] mem_delay  [TABLE_SLOTS];
    logic [31:0]        mem_target [TABLE_SLOTS];
    logic [31:0]        mem_data   [TABLE_SLOTS];
    logic [3:0]         mem_kind   [TABLE_SLOTS];

    t_state             r_state;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_s1_valid;
    logic [IDX_W-1:0]   r_s1_idx;
    logic signed [16:0] r_rd_delay;
    logic [31:0]        r_rd_target;
    logic [31:0]        r_rd_data;
    logic [3:0]         r_rd_kind;
    logic               r_hold_v;
    t_out_word          r_hold_word;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [IDX_W-1:0]   cidx;
    logic               out_free;
    logic               issue_done;
    logic signed [16:0] s1_dec;
    logic               s1_live;
    logic               s1_expire;
    logic               s1_fire;
    t_out_word          s1_word;
    logic               n_emit;
    t_out_word          n_out_word;
    logic               we_all;
    logic               we_delay;
    logic [IDX_W-1:0]   w_addr;
    logic signed [16:0] w_delay;
    logic               rd_en;
    logic               tick_adv;
    logic               tick_end;
    logic               create_hit;
    logic               create_miss;
    logic               clr;

    assign cidx       = r_cnt[IDX_W-1:0];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign issue_done = (r_cnt == CNT_W'(TABLE_SLOTS));
    assign s1_dec     = r_rd_delay - 17'sd1;
    assign s1_live    = r_s1_valid && r_used[r_s1_idx];
    assign s1_expire  = (s1_dec <= 17'sd0);
    assign s1_fire    = s1_live && s1_expire && (r_rd_kind != 4'd0);

    always_comb begin
        s1_word              = '0;
        s1_word.result_code  = RC_FIRED;
        s1_word.slot_index   = 6'(r_s1_idx);
        s1_word.fired_target = r_rd_target;
        s1_word.fired_data   = r_rd_data;
        s1_word.fired_kind   = r_rd_kind;
    end

    always_comb begin
        n_emit      = 1'b0;
        n_out_word  = '0;
        o_pop       = 1'b0;
        we_all      = 1'b0;
        we_delay    = 1'b0;
        w_addr      = cidx;
        w_delay     = {1'b0, i_head.cmd.delay_ticks};
        rd_en       = 1'b0;
        tick_adv    = 1'b0;
        tick_end    = 1'b0;
        create_hit  = 1'b0;
        create_miss = 1'b0;
        clr         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid && i_head.cmd.op == OP_CLEAR && out_free) begin
                    clr                    = 1'b1;
                    o_pop                  = 1'b1;
                    n_emit                 = 1'b1;
                    n_out_word.result_code = RC_CLEARED;
                    n_out_word.last        = 1'b1;
                end
            end
            S_CREATE: begin
                if (!r_used[cidx]) begin
                    if (out_free) begin
                        create_hit             = 1'b1;
                        we_all                 = 1'b1;
                        o_pop                  = 1'b1;
                        n_emit                 = 1'b1;
                        n_out_word.result_code = RC_CREATED;
                        n_out_word.slot_index  = 6'(cidx);
                        n_out_word.last        = 1'b1;
                    end
                end else if (cidx == LAST_IDX) begin
                    if (out_free) begin
                        create_miss            = 1'b1;
                        o_pop                  = 1'b1;
                        n_emit                 = 1'b1;
                        n_out_word.result_code = RC_REFUSED;
                        n_out_word.last        = 1'b1;
                    end
                end
            end
            S_TICK: begin
                if (r_s1_valid || !issue_done) begin
                    tick_adv = !(s1_fire && r_hold_v && !out_free);
                    rd_en    = tick_adv && !issue_done;
                    if (tick_adv && s1_live) begin
                        we_delay = 1'b1;
                        w_addr   = r_s1_idx;
                        w_delay  = s1_dec;
                    end
                    if (tick_adv && s1_fire && r_hold_v) begin
                        n_emit     = 1'b1;
                        n_out_word = r_hold_word;
                    end
                end else if (out_free) begin
                    tick_end = 1'b1;
                    o_pop    = 1'b1;
                    n_emit   = 1'b1;
                    if (r_hold_v) begin
                        n_out_word      = r_hold_word;
                        n_out_word.last = 1'b1;
                    end else begin
                        n_out_word.result_code = RC_TICK_NONE;
                        n_out_word.last        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_all) begin
            mem_target[w_addr] <= i_head.cmd.target_address;
            mem_data[w_addr]   <= i_head.cmd.data_word;
            mem_kind[w_addr]   <= i_head.cmd.command_kind;
        end
        if (we_all || we_delay) begin
            mem_delay[w_addr] <= w_delay;
        end
        if (rd_en) begin
            r_rd_delay  <= mem_delay[cidx];
            r_rd_target <= mem_target[cidx];
            r_rd_data   <= mem_data[cidx];
            r_rd_kind   <= mem_kind[cidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_emit) begin
                r_out_valid <= 1'b1;
                r_out_word  <= n_out_word;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (clr) begin
                        r_used <= '0;
                    end else if (i_head.valid && i_head.cmd.op == OP_CREATE) begin
                        r_state <= S_CREATE;
                        r_cnt   <= '0;
                    end else if (i_head.valid && i_head.cmd.op == OP_TICK) begin
                        r_state    <= S_TICK;
                        r_cnt      <= '0;
                        r_s1_valid <= 1'b0;
                        r_hold_v   <= 1'b0;
                    end
                end
                S_CREATE: begin
                    if (create_hit) begin
                        r_used[cidx] <= 1'b1;
                        r_state      <= S_IDLE;
                    end else if (create_miss) begin
                        r_state <= S_IDLE;
                    end else if (r_used[cidx] && cidx != LAST_IDX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TICK: begin
                    if (tick_end) begin
                        r_state  <= S_IDLE;
                        r_hold_v <= 1'b0;
                    end else if (tick_adv) begin
                        r_s1_valid <= !issue_done;
                        r_s1_idx   <= cidx;
                        if (!issue_done) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (s1_live && s1_expire) begin
                            r_used[r_s1_idx] <= 1'b0;
                        end
                        if (s1_fire) begin
                            r_hold_v    <= 1'b1;
                            r_hold_word <= s1_word;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/delayed_command_timer_table_core.sv =====
// Top level of the delayed command timer table.
// Input channel: i_in_valid / o_in_stall carry one command word (tick, create,
// clear); action code 3 is taken and dropped. Output channel: o_out_valid /
// i_out_stall carry result words; the final word of a command has last set.
// Commands pass through a two-entry queue to the slot sequencer, so the input
// keeps accepting while a result waits in the output register.
// Create scans the used bits one slot per cycle from slot 0. Tick reads the
// slot memory one slot per cycle through a two-stage read/update pipe,
// pausing while a new firing meets a held word and a stalled output; each
// fired word is held until the next firing or the end of the scan so that
// last can be set.
// Sustained rate is bounded by the one-slot-per-cycle memory port.
// Reset empties the table at once (used bits are flops); no clearing pass.
// A stalled output holds the sequencer once it has a word to emit; the queue
// then fills and o_in_stall rises.
module delayed_command_timer_table_core #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dctt_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dctt_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import dctt_pkg::*;

    t_q_head head;
    logic    pop;

    dctt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_head     (head),
        .i_pop      (pop)
    );

    dctt_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== rtl/core/dctt_checker.sv =====
// Port-level checks of the timer table, bound to the top level.
`include "delayed_command_timer_table_core_macros.svh"

module dctt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input dctt_pkg::t_in_word  i_in_word,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input dctt_pkg::t_out_word o_out_word,
    input logic                i_out_stall
);
    import dctt_pkg::*;

    `DCTT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_in_word))

    `DCTT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_word))

    `DCTT_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n,
        o_out_valid && o_out_word.result_code != RC_FIRED,
        o_out_word.fired_target == 32'd0 && o_out_word.fired_data == 32'd0 &&
        o_out_word.fired_kind == 4'd0)

    `DCTT_ASSERT_NOW(a_single_is_last, i_clk, i_rst_n,
        o_out_valid && o_out_word.result_code != RC_FIRED, o_out_word.last)

    `DCTT_ASSERT_NOW(a_fired_kind, i_clk, i_rst_n,
        o_out_valid && o_out_word.result_code == RC_FIRED, o_out_word.fired_kind != 4'd0)

endmodule

bind delayed_command_timer_table_core dctt_checker u_dctt_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for the delayed command timer table: predicts results and checks each output word.
`timescale 1ns / 100ps

module tb;
    import dctt_pkg::*;

    localparam int SLOTS      = 64;
    localparam int WDOG_LIMIT = 5000;
    localparam int SETTLE     = 2 * SLOTS + 16;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int gap_pct   = 0;
    int stall_pct = 0;
    int fail_count = 0;

    // predicted table contents
    logic              slot_busy   [SLOTS];
    logic signed [16:0] slot_count [SLOTS];
    logic [31:0]       slot_target [SLOTS];
    logic [31:0]       slot_data   [SLOTS];
    logic [3:0]        slot_kind   [SLOTS];

    t_out_word expected_words[$];

    delayed_command_timer_table_core #(
        .TABLE_SLOTS(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    function automatic t_out_word status_word(input logic [2:0] code);
        t_out_word r;
        r = '0;
        r.result_code = code;
        r.last = 1'b1;
        return r;
    endfunction

    // Applies one command word to the predicted table and queues its results.
    function automatic void advance_timer_table(input t_in_word w);
        t_out_word r;
        t_out_word held;
        logic      have_held;
        r = status_word(RC_REFUSED);
        held = '0;
        have_held = 1'b0;
        case (w.action)
            ACT_CREATE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!slot_busy[s]) begin
                        slot_busy[s]   = 1'b1;
                        slot_count[s]  = {1'b0, w.delay_ticks};
                        slot_target[s] = w.target_address;
                        slot_data[s]   = w.data_word;
                        slot_kind[s]   = w.command_kind;
                        r.result_code  = RC_CREATED;
                        r.slot_index   = 6'(s);
                        break;
                    end
                end
                expected_words.push_back(r);
            end
            ACT_CLEAR: begin
                for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
                expected_words.push_back(status_word(RC_CLEARED));
            end
            ACT_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_busy[s]) begin
                        slot_count[s] = slot_count[s] - 17'sd1;
                        if (slot_count[s] <= 17'sd0) begin
                            if (slot_kind[s] != 4'd0) begin
                                if (have_held) expected_words.push_back(held);
                                held = '0;
                                held.result_code  = RC_FIRED;
                                held.slot_index   = 6'(s);
                                held.fired_target = slot_target[s];
                                held.fired_data   = slot_data[s];
                                held.fired_kind   = slot_kind[s];
                                have_held = 1'b1;
                            end
                            slot_busy[s] = 1'b0;
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expected_words.push_back(held);
                end else begin
                    expected_words.push_back(status_word(RC_TICK_NONE));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic string fmt_word(input t_out_word r);
        return $sformatf("code=%0d slot=%0d target=%h data=%h kind=%0d last=%0d",
                         r.result_code, r.slot_index, r.fired_target, r.fired_data,
                         r.fired_kind, r.last);
    endfunction

    function automatic bit words_match(input t_out_word a, input t_out_word b);
        return a.result_code === b.result_code && a.slot_index === b.slot_index &&
               a.fired_target === b.fired_target && a.fired_data === b.fired_data &&
               a.fired_kind === b.fired_kind && a.last === b.last;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %s",
                         $time, fmt_word(o_out_word));
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (!words_match(want, o_out_word)) begin
                    $display("%0t: mismatch, expected %s, actual %s",
                             $time, fmt_word(want), fmt_word(o_out_word));
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_timer_table(w);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_word op_word(input logic [1:0] act);
        t_in_word w;
        w = '0;
        w.action = act;
        return w;
    endfunction

    function automatic t_in_word create_word(input logic [15:0] delay, input logic [31:0] tgt,
                                             input logic [31:0] data, input logic [3:0] kind);
        t_in_word w;
        w.action         = ACT_CREATE;
        w.delay_ticks    = delay;
        w.target_address = tgt;
        w.data_word      = data;
        w.command_kind   = kind;
        return w;
    endfunction

    function automatic t_in_word random_word;
        t_in_word w;
        int       pick;
        logic [15:0] delay;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0:       delay = 16'hFFFF;
            1:       delay = 16'($urandom);
            default: delay = 16'($urandom_range(4));
        endcase
        w = create_word(delay, $urandom, $urandom, 4'($urandom_range(15)));
        if (pick >= 96)      w.action = ACT_NONE;
        else if (pick >= 90) w.action = ACT_CLEAR;
        else if (pick >= 48) w.action = ACT_TICK;
        return w;
    endfunction

    task automatic test_directed;
        t_in_word junk;
        junk = create_word(16'($urandom), $urandom, $urandom, 4'($urandom_range(15)));
        junk.action = ACT_NONE;
        send_word(op_word(ACT_TICK));
        send_word(op_word(ACT_CLEAR));
        send_word(junk);
        send_word(create_word(16'd0, 32'hFFFF_FFFF, 32'h0, 4'd1));
        send_word(create_word(16'd1, 32'h0, 32'hFFFF_FFFF, 4'd15));
        send_word(create_word(16'd2, $urandom, $urandom, 4'd0));
        send_word(create_word(16'hFFFF, $urandom, $urandom, 4'd7));
        send_word(op_word(ACT_TICK));
        send_word(op_word(ACT_TICK));
        send_word(create_word(16'd3, $urandom, $urandom, 4'd9));
        send_word(op_word(ACT_TICK));
        send_word(op_word(ACT_CLEAR));
        send_word(op_word(ACT_TICK));
        drain();
    endtask

    // fill every slot, get refused, then fire all slots on one tick
    task automatic test_table_full;
        for (int n = 0; n < SLOTS; n++)
            send_word(create_word(16'($urandom_range(1)), $urandom, $urandom,
                                  4'($urandom_range(15, 1))));
        send_word(create_word(16'($urandom), $urandom, $urandom, 4'($urandom_range(15))));
        send_word(op_word(ACT_TICK));
        send_word(op_word(ACT_TICK));
        drain();
    endtask

    task automatic test_random(input int gap, input int stall, input int count);
        gap_pct   = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++) send_word(random_word());
        drain();
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct   = 7;
        stall_pct = 49;
        test_directed();
        test_table_full();
        test_random(7, 49, 27);
        test_random(49, 7, 27);
        test_random(0, 0, 27);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_words.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
